// ----- rtl/set_assoc_writeback_cache_macros.svh -----
// Assertion macros for the set-associative write-back cache.
// Included by the top level; no other dependencies.
`ifndef SET_ASSOC_WRITEBACK_CACHE_MACROS_SVH
`define SET_ASSOC_WRITEBACK_CACHE_MACROS_SVH
`ifndef SYNTHESIS
`define SAWC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sawc assertion failed");
`define SAWC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sawc assertion failed");
`else
`define SAWC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SAWC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/sawc_pkg.sv -----
// Shared constants, types and helpers of the set-associative write-back cache.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package sawc_pkg;

   localparam int DATA_W        = 32;
   localparam int ADDR_W        = 18;
   localparam int TAG_W         = 12;
   localparam int LINE_ADDR_W   = 12;
   localparam int OFFSET_BITS   = 6;
   localparam int LINE_WORDS    = 16;
   localparam int WORD_IDX_W    = 4;
   localparam int WORD_CNT_W    = WORD_IDX_W + 1;
   localparam int LFSR_W        = 16;
   localparam int SIZE_W        = 5;
   localparam int WAYS_W        = 4;
   localparam int SHIFT_W       = 4;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 5;
   localparam int MAX_LINES_DEF = 2048;
   localparam int MEM_WORDS_DEF = 65536;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd14;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 5'd6;
   localparam logic [SIZE_W-1:0] SIZE_MAX   = 5'd17;
   localparam logic [WAYS_W-1:0] WAYS_RESET = 4'd2;
   localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd1;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   typedef struct packed {
      logic latch_req;
      logic cnt_zero;
      logic cnt_inc;
      logic clear;
      logic clr_mem;
      logic scan_rd;
      logic scan_chk;
      logic pick;
      logic vic_rd;
      logic vic_chk;
      logic wb_step;
      logic fill_step;
      logic acc_rd;
      logic acc_wr;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic scan_hit;
      logic scan_last;
      logic found;
      logic vic_dirty;
      logic word_last;
      logic cfg_write;
   } dp_status_type;

   // Word index into main memory before wrapping to its size.
   function automatic logic [LINE_ADDR_W+WORD_IDX_W-1:0] mem_word_index(
      input logic [LINE_ADDR_W-1:0] line_addr,
      input logic [WORD_IDX_W-1:0]  word);
      mem_word_index = {line_addr, word};
   endfunction

endpackage
`default_nettype wire

// ----- rtl/sawc_ctrl.sv -----
// Sequencer of the set-associative write-back cache: clearing passes, way scan,
// victim write-back, line fill and the final access. Uses sawc_pkg.
`default_nettype none
module sawc_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   input  sawc_pkg::dp_status_type status,
   output sawc_pkg::ctrl_cmd_type  cmd
);

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_SCAN_RD  = 4'd2;
   localparam logic [3:0] ST_SCAN_CHK = 4'd3;
   localparam logic [3:0] ST_PICK     = 4'd4;
   localparam logic [3:0] ST_VIC_RD   = 4'd5;
   localparam logic [3:0] ST_VIC_CHK  = 4'd6;
   localparam logic [3:0] ST_WB       = 4'd7;
   localparam logic [3:0] ST_FILL     = 4'd8;
   localparam logic [3:0] ST_ACC_RD   = 4'd9;
   localparam logic [3:0] ST_ACC_WR   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       clr_mem_ff, clr_mem_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      clr_mem_in   = clr_mem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear   = 1'b1;
            cmd.clr_mem = clr_mem_ff;
            cmd.cnt_inc = 1'b1;
            if (status.clr_last) begin
               state_in   = ST_IDLE;
               clr_mem_in = 1'b0;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               cmd.cnt_zero  = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd.scan_chk = 1'b1;
            if (status.scan_hit) begin
               state_in = ST_ACC_RD;
            end else if (status.scan_last) begin
               state_in = ST_PICK;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            if (status.found) begin
               cmd.cnt_zero = 1'b1;
               state_in     = ST_FILL;
            end else begin
               state_in = ST_VIC_RD;
            end
         end
         ST_VIC_RD: begin
            cmd.vic_rd = 1'b1;
            state_in   = ST_VIC_CHK;
         end
         ST_VIC_CHK: begin
            cmd.vic_chk  = 1'b1;
            cmd.cnt_zero = 1'b1;
            state_in     = status.vic_dirty ? ST_WB : ST_FILL;
         end
         ST_WB: begin
            cmd.wb_step = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (status.word_last) begin
               cmd.cnt_zero = 1'b1;
               state_in     = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            cmd.cnt_inc   = 1'b1;
            if (status.word_last) begin
               state_in = ST_ACC_RD;
            end
         end
         ST_ACC_RD: begin
            cmd.acc_rd = 1'b1;
            state_in   = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            // The result register must be free before the access commits.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.acc_wr   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // A register write drops every line; a pass clearing main memory carries on.
      // A word offered in the same cycle waits until the pass is over.
      if (status.cfg_write) begin
         cmd.latch_req = 1'b0;
         cmd.cnt_zero  = 1'b1;
         req_ready     = 1'b0;
         clr_mem_in    = (state_ff == ST_CLEAR) && clr_mem_ff;
         state_in      = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_mem_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_mem_ff   <= clr_mem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- rtl/sawc_datapath.sv -----
// Datapath of the set-associative write-back cache: configuration, line state,
// line data, main memory, victim LFSR and result register. Uses sawc_pkg.
`default_nettype none
module sawc_datapath #(
   parameter int MAX_LINES = sawc_pkg::MAX_LINES_DEF,
   parameter int MEM_WORDS = sawc_pkg::MEM_WORDS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  sawc_pkg::ctrl_cmd_type               cmd,
   output sawc_pkg::dp_status_type              status,
   input  wire                                  csr_valid,
   input  wire  [sawc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [sawc_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire                                  req_opcode,
   input  wire  [sawc_pkg::ADDR_W-1:0]          req_byte_address,
   input  wire  [sawc_pkg::DATA_W-1:0]          req_write_data,
   input  wire  [sawc_pkg::DATA_W-1:0]          req_write_mask,
   output logic [sawc_pkg::DATA_W-1:0]          rsp_read_word,
   output logic                                 rsp_was_hit,
   output logic                                 rsp_did_writeback
);

   localparam int LIW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int DIW = LIW + sawc_pkg::WORD_IDX_W;
   localparam int MAW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
   localparam int CW  = (MAW > sawc_pkg::LINE_ADDR_W) ? MAW : sawc_pkg::LINE_ADDR_W;
   localparam int LAW = sawc_pkg::LINE_ADDR_W;
   localparam int WIW = sawc_pkg::WORD_IDX_W;
   localparam int DW  = sawc_pkg::DATA_W;

   typedef struct packed {
      logic                        valid;
      logic                        dirty;
      logic [sawc_pkg::TAG_W-1:0]  tag;
   } meta_type;

   // Configuration registers.
   logic [sawc_pkg::SIZE_W-1:0] size_ff;
   logic [sawc_pkg::WAYS_W-1:0] ways_ff;
   logic                        cfg_size_wr, cfg_ways_wr;

   assign cfg_size_wr = csr_valid && (csr_index == sawc_pkg::CSR_CACHE_SIZE);
   assign cfg_ways_wr = csr_valid && (csr_index == sawc_pkg::CSR_WAYS);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= sawc_pkg::SIZE_RESET;
         ways_ff <= sawc_pkg::WAYS_RESET;
      end else begin
         if (cfg_size_wr) size_ff <= csr_data[sawc_pkg::SIZE_W-1:0];
         if (cfg_ways_wr) ways_ff <= csr_data[sawc_pkg::WAYS_W-1:0];
      end
   end

   // Effective geometry.
   logic [sawc_pkg::SIZE_W-1:0]  eff_size;
   logic [sawc_pkg::SHIFT_W-1:0] lim, wl, sl;
   logic [LAW-1:0]               line_addr, set_idx, tag_idx;

   always_comb begin
      if (size_ff < sawc_pkg::SIZE_MIN) eff_size = sawc_pkg::SIZE_MIN;
      else if (size_ff > sawc_pkg::SIZE_MAX) eff_size = sawc_pkg::SIZE_MAX;
      else eff_size = size_ff;
      lim       = sawc_pkg::SHIFT_W'(eff_size - sawc_pkg::SIZE_MIN);
      wl        = (ways_ff > lim) ? lim : ways_ff;
      sl        = lim - wl;
      line_addr = req_byte_address[sawc_pkg::ADDR_W-1:sawc_pkg::OFFSET_BITS];
      set_idx   = line_addr & ~({LAW{1'b1}} << sl);
      tag_idx   = line_addr >> sl;
   end

   // Request registers.
   logic           op_ff;
   logic [DW-1:0]  wdata_ff, wmask_ff;
   logic [LAW-1:0] laddr_ff, set_ff, tag_ff, start_ff, waymask_ff;
   logic [WIW-1:0] word_ff;
   logic [sawc_pkg::SHIFT_W-1:0] sl_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff      <= req_opcode;
         wdata_ff   <= req_write_data;
         wmask_ff   <= req_write_mask;
         laddr_ff   <= line_addr;
         set_ff     <= set_idx;
         tag_ff     <= tag_idx;
         start_ff   <= set_idx << wl;
         waymask_ff <= ~({LAW{1'b1}} << wl);
         word_ff    <= req_byte_address[sawc_pkg::OFFSET_BITS-1:2];
         sl_ff      <= sl;
      end
   end

   // Shared step counter.
   logic [CW-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.cnt_zero) cnt_ff <= '0;
      else if (cmd.cnt_inc) cnt_ff <= cnt_ff + 1'b1;
   end

   logic [WIW-1:0] word_cur, word_prev;
   logic           word_rd_en, word_wr_en;

   assign word_cur   = cnt_ff[WIW-1:0];
   assign word_prev  = word_cur - 1'b1;
   assign word_rd_en = !cnt_ff[WIW];
   assign word_wr_en = (cnt_ff[WIW:0] != '0);

   // Line state memory.
   meta_type         meta_mem [1 << LIW];
   meta_type         meta_q;
   logic [LIW-1:0]   scan_line, line_ff, free_ff;
   logic             hit_ff, found_ff, dirty_old_ff, wb_ff;
   logic [LAW-1:0]   vtag_ff;
   logic             meta_we;
   logic [LIW-1:0]   meta_wa, meta_ra;
   meta_type         meta_wd;
   logic             dirty_new;

   assign scan_line = LIW'(start_ff + cnt_ff[LAW-1:0]);
   assign dirty_new = hit_ff ? (dirty_old_ff || (op_ff == sawc_pkg::OP_WRITE))
                             : (op_ff == sawc_pkg::OP_WRITE);

   always_comb begin
      meta_we = 1'b0;
      meta_wa = line_ff;
      meta_wd = '{valid: 1'b1, dirty: dirty_new, tag: tag_ff};
      if (cmd.clear) begin
         meta_we = ((cnt_ff >> LIW) == '0);
         meta_wa = cnt_ff[LIW-1:0];
         meta_wd = '0;
      end else if (cmd.acc_wr) begin
         meta_we = 1'b1;
      end
      meta_ra = cmd.scan_rd ? scan_line : line_ff;
   end

   always_ff @(posedge clock) begin
      if (meta_we) meta_mem[meta_wa] <= meta_wd;
      if (cmd.scan_rd || cmd.vic_rd) meta_q <= meta_mem[meta_ra];
   end

   logic [sawc_pkg::LFSR_W-1:0] lfsr_ff;
   logic                        lfsr_fb;

   assign lfsr_fb = lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= sawc_pkg::LFSR_SEED;
      end else if (cmd.pick && !found_ff) begin
         lfsr_ff <= {lfsr_fb, lfsr_ff[sawc_pkg::LFSR_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         hit_ff   <= 1'b0;
         found_ff <= 1'b0;
         wb_ff    <= 1'b0;
      end
      if (cmd.scan_chk) begin
         if (status.scan_hit) begin
            hit_ff       <= 1'b1;
            line_ff      <= scan_line;
            dirty_old_ff <= meta_q.dirty;
         end else if (!meta_q.valid && !found_ff) begin
            found_ff <= 1'b1;
            free_ff  <= scan_line;
         end
      end
      if (cmd.pick) begin
         line_ff <= found_ff ? free_ff
                             : LIW'(start_ff + (lfsr_ff[LAW-1:0] & waymask_ff));
      end
      if (cmd.vic_chk) begin
         wb_ff   <= meta_q.dirty;
         vtag_ff <= meta_q.tag;
      end
   end

   // Line data memory.
   logic [DW-1:0]  data_mem [(1 << LIW) * sawc_pkg::LINE_WORDS];
   logic [DW-1:0]  data_q, mem_q, merged;
   logic [DIW-1:0] data_ra, data_wa;
   logic [DW-1:0]  data_wd;
   logic           data_re, data_we;

   assign merged = (data_q & ~wmask_ff) | (wdata_ff & wmask_ff);

   always_comb begin
      data_re = 1'b0;
      data_ra = {line_ff, word_ff};
      data_we = 1'b0;
      data_wa = {line_ff, word_prev};
      data_wd = mem_q;
      if (cmd.wb_step) begin
         data_re = word_rd_en;
         data_ra = {line_ff, word_cur};
      end
      if (cmd.acc_rd) data_re = 1'b1;
      if (cmd.fill_step) data_we = word_wr_en;
      if (cmd.acc_wr && (op_ff == sawc_pkg::OP_WRITE)) begin
         data_we = 1'b1;
         data_wa = {line_ff, word_ff};
         data_wd = merged;
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) data_mem[data_wa] <= data_wd;
      if (data_re) data_q <= data_mem[data_ra];
   end

   // Main memory.
   logic [DW-1:0]  main_mem [MEM_WORDS];
   logic [LAW-1:0] wb_laddr;
   logic [MAW-1:0] mem_wa, mem_ra;
   logic [DW-1:0]  mem_wd;
   logic           mem_we, mem_re;

   assign wb_laddr = (vtag_ff << sl_ff) | set_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = MAW'(sawc_pkg::mem_word_index(wb_laddr, word_prev));
      mem_wd = data_q;
      if (cmd.clear && cmd.clr_mem) begin
         mem_we = 1'b1;
         mem_wa = cnt_ff[MAW-1:0];
         mem_wd = '0;
      end else if (cmd.wb_step) begin
         mem_we = word_wr_en;
      end
      mem_re = cmd.fill_step && word_rd_en;
      mem_ra = MAW'(sawc_pkg::mem_word_index(laddr_ff, word_cur));
   end

   always_ff @(posedge clock) begin
      if (mem_we) main_mem[mem_wa] <= mem_wd;
      if (mem_re) mem_q <= main_mem[mem_ra];
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.acc_wr) begin
         rsp_read_word     <= (op_ff == sawc_pkg::OP_WRITE) ? merged : data_q;
         rsp_was_hit       <= hit_ff;
         rsp_did_writeback <= wb_ff;
      end
   end

   always_comb begin
      status.clr_last  = cmd.clr_mem ? (cnt_ff == CW'(MEM_WORDS - 1))
                                     : (cnt_ff == CW'(MAX_LINES - 1));
      status.scan_hit  = meta_q.valid && (meta_q.tag == tag_ff);
      status.scan_last = (cnt_ff[LAW-1:0] == waymask_ff);
      status.found     = found_ff;
      status.vic_dirty = meta_q.dirty;
      status.word_last = (cnt_ff[WIW:0] == (WIW+1)'(sawc_pkg::LINE_WORDS));
      status.cfg_write = cfg_size_wr || cfg_ways_wr;
   end

endmodule
`default_nettype wire

// ----- rtl/set_assoc_writeback_cache.sv -----
// Set-associative write-back, write-allocate cache with its own main memory.
//
// Channels: req_* carries one word access (read, or write merged under a bit
// mask); rsp_* returns one word per access with hit and write-back flags;
// csr_* writes the size and way-count registers and is always ready.
// A write to the size or way-count register invalidates every line; no word is
// accepted during the pass, including a word offered in the cycle of the write.
// After reset, main memory (MEM_WORDS words, 65536 by default) and the line
// state are cleared before the first word is accepted.
// An access scans the ways of its set in order until a tag hits. A miss
// takes a free way if the scan found one, else an LFSR-picked victim whose
// state is read; a dirty victim is written back, then the line is filled
// ahead of the final access. The way scan reads one tag at a time from the
// line state memory, and line copies move one word per cycle. One access is
// handled at a time; the next word can be taken in the same cycle that the
// result becomes valid, at the earliest. The result sits in an output
// register; a stalled receiver holds the next access in its final step until
// the register frees, while the request side may already present the next word.
// Uses sawc_pkg, sawc_ctrl, sawc_datapath and the assertion macro header.
`default_nettype none
`include "set_assoc_writeback_cache_macros.svh"
module set_assoc_writeback_cache #(
   parameter int MAX_LINES = sawc_pkg::MAX_LINES_DEF,
   parameter int MEM_WORDS = sawc_pkg::MEM_WORDS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_opcode,
   input  wire  [sawc_pkg::ADDR_W-1:0]       req_byte_address,
   input  wire  [sawc_pkg::DATA_W-1:0]       req_write_data,
   input  wire  [sawc_pkg::DATA_W-1:0]       req_write_mask,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [sawc_pkg::DATA_W-1:0]       rsp_read_word,
   output logic                              rsp_was_hit,
   output logic                              rsp_did_writeback,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [sawc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [sawc_pkg::CSR_DATA_W-1:0]   csr_data
);

   sawc_pkg::ctrl_cmd_type  cmd;
   sawc_pkg::dp_status_type status;
   logic                    cfg_reg_write;

   assign csr_ready = 1'b1;
   assign cfg_reg_write = csr_valid && csr_ready &&
                          (csr_index == sawc_pkg::CSR_CACHE_SIZE ||
                           csr_index == sawc_pkg::CSR_WAYS);

   sawc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sawc_datapath #(
      .MAX_LINES (MAX_LINES),
      .MEM_WORDS (MEM_WORDS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_opcode        (req_opcode),
      .req_byte_address  (req_byte_address),
      .req_write_data    (req_write_data),
      .req_write_mask    (req_write_mask),
      .rsp_read_word     (rsp_read_word),
      .rsp_was_hit       (rsp_was_hit),
      .rsp_did_writeback (rsp_did_writeback)
   );

   // An accepted word keeps the request side closed while it is processed.
   `SAWC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // Reset starts the clearing pass.
   `SAWC_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, !req_ready)
   // A register write starts an invalidation pass.
   `SAWC_ASSERT_NEXT(a_clear_after_cfg, clock, reset, cfg_reg_write, !req_ready)
   // A hit never evicts.
   `SAWC_ASSERT_SAME(a_hit_no_writeback, clock, reset, rsp_valid, !(rsp_was_hit && rsp_did_writeback))

endmodule
`default_nettype wire

// ----- sim/set_assoc_writeback_cache_checker.sv -----
// Checker for the set-associative write-back cache: predicts every result word and
// its flags from the accepted request and register words. Depends on sawc_pkg.
`timescale 1ns / 100ps
`default_nettype none
module set_assoc_writeback_cache_checker (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire                              req_ready,
   input  wire                              req_opcode,
   input  wire [sawc_pkg::ADDR_W-1:0]       req_byte_address,
   input  wire [sawc_pkg::DATA_W-1:0]       req_write_data,
   input  wire [sawc_pkg::DATA_W-1:0]       req_write_mask,
   input  wire                              rsp_valid,
   input  wire                              rsp_ready,
   input  wire [sawc_pkg::DATA_W-1:0]       rsp_read_word,
   input  wire                              rsp_was_hit,
   input  wire                              rsp_did_writeback,
   input  wire                              csr_valid,
   input  wire                              csr_ready,
   input  wire [sawc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [sawc_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                               error_count,
   output int                               pending_count,
   output int                               hit_count,
   output int                               writeback_count
);

   typedef struct {
      logic [sawc_pkg::DATA_W-1:0] word;
      logic                        hit;
      logic                        wb;
   } access_result_type;

   access_result_type           awaited_results[$];
   logic [sawc_pkg::SIZE_W-1:0] size_reg;
   logic [sawc_pkg::WAYS_W-1:0] ways_reg;
   logic [sawc_pkg::LFSR_W-1:0] victim_lfsr;
   bit                          line_valid[2048];
   bit                          line_dirty[2048];
   logic [sawc_pkg::TAG_W-1:0]  line_tag[2048];
   logic [sawc_pkg::DATA_W-1:0] line_data[2048*16];
   logic [sawc_pkg::DATA_W-1:0] memory[65536];

   function automatic access_result_type cache_access(input logic op,
         input logic [sawc_pkg::ADDR_W-1:0] addr, input logic [sawc_pkg::DATA_W-1:0] data,
         input logic [sawc_pkg::DATA_W-1:0] mask);
      int unsigned       esize, wl, sl, ways, set, tag, word, start, line, l, la;
      bit                hit, found;
      logic              fb;
      access_result_type r;
      esize = size_reg;
      if (esize < 6) esize = 6;
      if (esize > 17) esize = 17;
      wl = (ways_reg > esize - 6) ? esize - 6 : ways_reg;
      sl = esize - 6 - wl;
      ways = 1 << wl;
      set = (addr >> 6) & ((1 << sl) - 1);
      tag = addr >> (6 + sl);
      word = addr[5:2];
      start = set * ways;
      line = 0;
      hit = 0;
      found = 0;
      r.wb = 0;
      for (int i = 0; i < ways && !hit; i++) begin
         l = (start + i) & 2047;
         if (line_valid[l] && line_tag[l] == tag) begin
            line = l;
            hit = 1;
         end
      end
      if (!hit) begin
         for (int i = 0; i < ways && !found; i++) begin
            l = (start + i) & 2047;
            if (!line_valid[l]) begin
               line = l;
               found = 1;
            end
         end
         if (!found) begin
            line = (start + (victim_lfsr & (ways - 1))) & 2047;
            fb = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
            victim_lfsr = {fb, victim_lfsr[15:1]};
            if (line_dirty[line]) begin
               la = (line_tag[line] << sl) | set;
               for (int i = 0; i < 16; i++)
                  memory[(la * 16 + i) & 16'hffff] = line_data[line * 16 + i];
               r.wb = 1;
            end
         end
         la = addr >> 6;
         for (int i = 0; i < 16; i++)
            line_data[line * 16 + i] = memory[(la * 16 + i) & 16'hffff];
         line_valid[line] = 1;
         line_dirty[line] = 0;
         line_tag[line] = tag;
      end
      if (op == sawc_pkg::OP_WRITE) begin
         line_data[line * 16 + word] = (line_data[line * 16 + word] & ~mask) | (data & mask);
         line_dirty[line] = 1;
      end
      r.word = line_data[line * 16 + word];
      r.hit = hit;
      return r;
   endfunction

   always @(posedge clock) begin
      access_result_type exp_r;
      if (reset) begin
         size_reg <= sawc_pkg::SIZE_RESET;
         ways_reg <= sawc_pkg::WAYS_RESET;
         victim_lfsr = sawc_pkg::LFSR_SEED;
         for (int i = 0; i < 2048; i++) begin
            line_valid[i] = 0;
            line_dirty[i] = 0;
         end
         for (int i = 0; i < 65536; i++) memory[i] = '0;
         awaited_results.delete();
         error_count <= 0;
         hit_count <= 0;
         writeback_count <= 0;
      end else begin
         if (csr_valid && csr_ready && (csr_index == sawc_pkg::CSR_CACHE_SIZE ||
                                        csr_index == sawc_pkg::CSR_WAYS))
         begin
            if (csr_index == sawc_pkg::CSR_CACHE_SIZE) size_reg <= csr_data;
            else ways_reg <= csr_data[sawc_pkg::WAYS_W-1:0];
            for (int i = 0; i < 2048; i++) begin
               line_valid[i] = 0;
               line_dirty[i] = 0;
            end
         end
         // Responses are taken before new requests, so a word never meets its own prediction.
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_read_word);
               error_count <= error_count + 1;
            end else begin
               exp_r = awaited_results.pop_front();
               if (rsp_read_word !== exp_r.word || rsp_was_hit !== exp_r.hit ||
                   rsp_did_writeback !== exp_r.wb) begin
                  $display("%0t: expected word %h hit %b wb %b, got word %h hit %b wb %b",
                           $time, exp_r.word, exp_r.hit, exp_r.wb,
                           rsp_read_word, rsp_was_hit, rsp_did_writeback);
                  error_count <= error_count + 1;
               end
               hit_count <= hit_count + exp_r.hit;
               writeback_count <= writeback_count + exp_r.wb;
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(cache_access(req_opcode, req_byte_address,
                                                   req_write_data, req_write_mask));
      end
      pending_count <= awaited_results.size();
   end

endmodule
`default_nettype wire

// ----- sim/tb_set_assoc_writeback_cache.sv -----
// Top of the cache testbench: clock, reset, request and register stimulus,
// receiver stalls, watchdog and verdict. Depends on sawc_pkg and the checker.
`timescale 1ns / 100ps
`default_nettype none
module tb_set_assoc_writeback_cache;

   localparam int WATCHDOG_LIMIT = 250000;
   localparam logic [sawc_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [sawc_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic [sawc_pkg::CSR_DATA_W-1:0] SIZE_SEQ[8] =
      '{5'd6, 5'd17, 5'd10, 5'd31, 5'd3, 5'd8, 5'd12, 5'd14};
   localparam logic [sawc_pkg::CSR_DATA_W-1:0] WAYS_SEQ[8] =
      '{5'd0, 5'd11, 5'd3, 5'd15, 5'd5, 5'd1, 5'd7, 5'd2};

   logic                            clock, reset;
   logic                            req_valid, req_ready, req_opcode;
   logic [sawc_pkg::ADDR_W-1:0]     req_byte_address;
   logic [sawc_pkg::DATA_W-1:0]     req_write_data, req_write_mask;
   logic                            rsp_valid, rsp_ready, rsp_was_hit, rsp_did_writeback;
   logic [sawc_pkg::DATA_W-1:0]     rsp_read_word;
   logic                            csr_valid, csr_ready;
   logic [sawc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sawc_pkg::CSR_DATA_W-1:0] csr_data;
   int                              error_count, pending_count, hit_count, writeback_count;
   int                              word_count, idle_cycles;
   bit                              calm;

   set_assoc_writeback_cache dut (.*);

   set_assoc_writeback_cache_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   task automatic send_word(input logic op, input logic [sawc_pkg::ADDR_W-1:0] addr,
                            input logic [sawc_pkg::DATA_W-1:0] data,
                            input logic [sawc_pkg::DATA_W-1:0] mask);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_byte_address <= addr;
      req_write_data <= data;
      req_write_mask <= mask;
      do @(posedge clock); while (!(req_valid && req_ready));
      word_count++;
   endtask

   // Holds off the sender until every predicted result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input logic [sawc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sawc_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [sawc_pkg::DATA_W-1:0] pick_mask();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly a few tags spread over few sets, so that sets fill up and evict.
   function automatic logic [sawc_pkg::ADDR_W-1:0] pick_address();
      logic [sawc_pkg::LINE_ADDR_W-1:0] la;
      logic [31:0]                      r;
      r = $urandom;
      if ($urandom_range(0, 9) < 3) return r[sawc_pkg::ADDR_W-1:0];
      r = ($urandom_range(0, 7) << $urandom_range(2, 9)) | $urandom_range(0, 3);
      la = r[sawc_pkg::LINE_ADDR_W-1:0];
      return {la, 4'($urandom), 2'($urandom)};
   endfunction

   initial begin
      rsp_ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         int gap;
         gap = draw_gap();
         if (gap != 0) begin
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired at %0t", $time);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int items;
      reset = 1;
      req_valid = 0;
      req_opcode = sawc_pkg::OP_READ;
      req_byte_address = '0;
      req_write_data = '0;
      req_write_mask = '0;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      word_count = 0;
      calm = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Default geometry: 64 sets of 4 ways, so a 4 KiB stride hits one set.
      send_word(sawc_pkg::OP_READ, '0, '0, '0);
      send_word(sawc_pkg::OP_READ, '1, '0, '0);
      send_word(sawc_pkg::OP_WRITE, '1, '1, '1);
      send_word(sawc_pkg::OP_WRITE, '1, '0, 32'h0000ffff);
      send_word(sawc_pkg::OP_WRITE, 18'h4, 32'hdeadbeef, '0);
      send_word(sawc_pkg::OP_READ, 18'h7, '0, '0);
      for (int t = 0; t < 6; t++)
         send_word(sawc_pkg::OP_WRITE, 18'(t * 4096 + 8), 32'h1111_0000 + t, '1);
      for (int t = 0; t < 6; t++)
         send_word(sawc_pkg::OP_READ, 18'(t * 4096 + 8), '0, '0);
      calm = 0;
      drain();

      for (int p = 0; p < 8; p++) begin
         write_reg(sawc_pkg::CSR_CACHE_SIZE, SIZE_SEQ[p]);
         write_reg(sawc_pkg::CSR_WAYS, WAYS_SEQ[p]);
         if (p == 2) write_reg(CSR_SPARE_LO, '1);
         if (p == 5) write_reg(CSR_SPARE_HI, '0);
         calm = ($urandom_range(0, 3) == 0);
         // Thousands of ways make every miss a long scan, so those runs stay short.
         items = (WAYS_SEQ[p] >= 8 && SIZE_SEQ[p] >= 17) ? 20 : 240;
         for (int i = 0; i < items; i++)
            send_word(1'($urandom), pick_address(), $urandom, pick_mask());
         drain();
      end

      $display("Covered %0d words over 9 cache geometries: %0d hits, %0d write-backs.",
               word_count, hit_count, writeback_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
`default_nettype wire
